### hdl/tiled_surface_address_swizzle_core_macros.svh
// Assertion macros for the tiled surface address block.
// Each macro expects clk and rst_n in scope.
`ifndef TILED_SURFACE_ADDRESS_SWIZZLE_CORE_MACROS_SVH
`define TILED_SURFACE_ADDRESS_SWIZZLE_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define TSAS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tsas check failed");

// next-cycle implication
`define TSAS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tsas check failed");

`else

`define TSAS_ASSERT_NOW(label, ante, cons)
`define TSAS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### hdl/tsas_pkg.sv
package tsas_pkg;

    // largest surface dimension; coordinates are sized from it
    localparam int MAX_DIM       = 16384;
    localparam int COORD_W       = $clog2(MAX_DIM);
    localparam int WIDTH_W       = COORD_W + 1;
    localparam int CODE_W        = 3;

    // tile geometry
    localparam int TILE_LOG2     = 16;          // 64 KiB tiles
    localparam int TILE_MIN_LOG2 = 6;           // smallest tile side (texels)
    localparam int SWZ_BITS      = 8;           // coordinate bits fed to the XOR tables
    localparam int SWZ_W         = 16;
    localparam int LOCAL_W       = SWZ_W + 1;   // room for the 2-byte shift
    localparam int SHIFT_W       = 4;

    // tile index and offset widths
    localparam int ROW_W         = COORD_W - TILE_MIN_LOG2;
    localparam int TPR_W         = WIDTH_W + 1 - TILE_MIN_LOG2;
    localparam int PROD_W        = ROW_W + TPR_W;
    localparam int IDX_W         = PROD_W + 1;
    localparam int SUM_W         = IDX_W + TILE_LOG2 + 1;
    localparam int OFFS_W        = 32;

    // configuration register indexes
    localparam int CFG_IDX_W     = 1;
    localparam logic [CFG_IDX_W-1:0] REG_TEXEL_SIZE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SURFACE_WIDTH = 1'd1;

    // texel size codes
    localparam logic [CODE_W-1:0] SIZE_1B  = 3'd0;
    localparam logic [CODE_W-1:0] SIZE_2B  = 3'd1;
    localparam logic [CODE_W-1:0] SIZE_4B  = 3'd2;
    localparam logic [CODE_W-1:0] SIZE_8B  = 3'd3;
    localparam logic [CODE_W-1:0] SIZE_16B = 3'd4;

    localparam logic [CODE_W-1:0]  RST_TEXEL_SIZE    = SIZE_4B;
    localparam logic [WIDTH_W-1:0] RST_SURFACE_WIDTH = '0;

    // XOR masks per size code, one entry per coordinate bit
    localparam logic [SWZ_W-1:0] X_MASKS [0:4][0:SWZ_BITS-1] = '{
        '{16'h0001, 16'h0002, 16'h0004, 16'h0140, 16'h0200, 16'h0800, 16'h2400, 16'h8000},
        '{16'h0001, 16'h0002, 16'h0004, 16'h00c0, 16'h0100, 16'h0400, 16'h1200, 16'h4000},
        '{16'h0004, 16'h0008, 16'h0080, 16'h0100, 16'h2200, 16'h0800, 16'h8400, 16'h0000},
        '{16'h0008, 16'h0020, 16'h0040, 16'h2100, 16'h0200, 16'h0800, 16'h8400, 16'h0000},
        '{16'h0010, 16'h0040, 16'h2000, 16'h0100, 16'h8200, 16'h0800, 16'h0400, 16'h0000}
    };
    localparam logic [SWZ_W-1:0] Y_MASKS [0:4][0:SWZ_BITS-1] = '{
        '{16'h0010, 16'h0008, 16'h0020, 16'h0100, 16'h0280, 16'h0400, 16'h1800, 16'h4000},
        '{16'h0008, 16'h0010, 16'h0020, 16'h0080, 16'h0900, 16'h0200, 16'h2400, 16'h0000},
        '{16'h0010, 16'h0020, 16'h0040, 16'h1100, 16'h0200, 16'h0400, 16'h4800, 16'h0000},
        '{16'h0010, 16'h0080, 16'h1000, 16'h0100, 16'h4200, 16'h0400, 16'h0800, 16'h0000},
        '{16'h0020, 16'h0080, 16'h1000, 16'h4100, 16'h0200, 16'h0400, 16'h0800, 16'h0000}
    };

    // map invalid codes onto a legal table row (result is discarded anyway)
    function automatic logic [CODE_W-1:0] safe_code(input logic [CODE_W-1:0] code);
        return (code > SIZE_16B) ? SIZE_1B : code;
    endfunction

    // log2 of tile width in texels
    function automatic logic [SHIFT_W-1:0] tile_w_log2(input logic [CODE_W-1:0] code);
        logic [SHIFT_W-1:0] r;
        case (code)
            SIZE_1B:  r = 4'd8;
            SIZE_2B:  r = 4'd8;
            SIZE_4B:  r = 4'd7;
            SIZE_8B:  r = 4'd7;
            SIZE_16B: r = 4'd6;
            default:  r = 4'd8;
        endcase
        return r;
    endfunction

    // log2 of tile height in texels
    function automatic logic [SHIFT_W-1:0] tile_h_log2(input logic [CODE_W-1:0] code);
        logic [SHIFT_W-1:0] r;
        case (code)
            SIZE_1B:  r = 4'd8;
            SIZE_2B:  r = 4'd7;
            SIZE_4B:  r = 4'd7;
            SIZE_8B:  r = 4'd6;
            SIZE_16B: r = 4'd6;
            default:  r = 4'd8;
        endcase
        return r;
    endfunction

    // XOR of the masks for every set low coordinate bit
    function automatic logic [SWZ_W-1:0] swizzle(
        input logic [CODE_W-1:0]  code,
        input logic [COORD_W-1:0] x,
        input logic [COORD_W-1:0] y
    );
        logic [SWZ_W-1:0]  acc;
        logic [CODE_W-1:0] sel;
        acc = '0;
        sel = safe_code(code);
        for (int b = 0; b < SWZ_BITS; b++)
        begin
            if (x[b])
                acc = acc ^ X_MASKS[sel][b];
            if (y[b])
                acc = acc ^ Y_MASKS[sel][b];
        end
        return acc;
    endfunction

endpackage

### hdl/tiled_surface_address_swizzle_core.sv
// Tiled surface address generator: turns a texel coordinate (coord_x, coord_y)
// into the byte offset of that texel in a surface of 64 KiB XOR-swizzled tiles,
// using the texel size code and surface width from the configuration port.
// One word is accepted per cycle as long as out_ready stays high, and each
// result passes through registered stages (input decode and swizzle, tile
// row multiply, final add and overflow check) in that order; a low
// out_ready stalls the pipeline in place without loss. Zero width, x at or
// beyond the width, an invalid size code or an offset beyond 32 bits give
// addr_error = 1 with byte_offset = 0. Configuration must be written only
// while no words are in flight.
`include "tiled_surface_address_swizzle_core_macros.svh"

module tiled_surface_address_swizzle_core (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_we,
    input  logic [tsas_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  logic [tsas_pkg::WIDTH_W-1:0]        cfg_wdata,
    // coordinate input
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [tsas_pkg::COORD_W-1:0]        coord_x,
    input  logic [tsas_pkg::COORD_W-1:0]        coord_y,
    // address output
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [tsas_pkg::OFFS_W-1:0]         byte_offset,
    output logic                                addr_error
);

    // configuration registers
    logic [tsas_pkg::CODE_W-1:0]  size_code_reg;
    logic [tsas_pkg::WIDTH_W-1:0] surf_width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_code_reg  <= tsas_pkg::RST_TEXEL_SIZE;
            surf_width_reg <= tsas_pkg::RST_SURFACE_WIDTH;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                tsas_pkg::REG_TEXEL_SIZE:    size_code_reg  <= cfg_wdata[tsas_pkg::CODE_W-1:0];
                tsas_pkg::REG_SURFACE_WIDTH: surf_width_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // pipeline flow control
    logic v1_reg, v2_reg, v3_reg;
    logic ready1, ready2, ready3;

    assign ready3   = !v3_reg || out_ready;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign in_ready = ready1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
                v1_reg <= in_valid;
            if (ready2)
                v2_reg <= v1_reg;
            if (ready3)
                v3_reg <= v2_reg;
        end
    end

    // stage 1: range check, swizzle, tile coordinates, tiles per row
    logic                                err1_next;
    logic [tsas_pkg::LOCAL_W-1:0]        local1_next;
    logic [tsas_pkg::SWZ_W-1:0]          swz;
    logic [tsas_pkg::SHIFT_W-1:0]        tw_sh, th_sh;
    logic [tsas_pkg::WIDTH_W:0]          round_mask;
    logic [tsas_pkg::WIDTH_W:0]          width_up;
    logic [tsas_pkg::WIDTH_W:0]          tpr_full;
    logic [tsas_pkg::COORD_W-1:0]        col_full, row_full;

    always_comb
    begin
        err1_next = (surf_width_reg == '0)
                 || ({1'b0, coord_x} >= surf_width_reg)
                 || (size_code_reg > tsas_pkg::SIZE_16B);
        swz   = tsas_pkg::swizzle(size_code_reg, coord_x, coord_y);
        tw_sh = tsas_pkg::tile_w_log2(size_code_reg);
        th_sh = tsas_pkg::tile_h_log2(size_code_reg);
        // 2-byte texels shift the in-tile offset by one
        if (size_code_reg == tsas_pkg::SIZE_2B)
            local1_next = {swz, 1'b0};
        else
            local1_next = {1'b0, swz};
        round_mask = ~({(tsas_pkg::WIDTH_W+1){1'b1}} << tw_sh);
        width_up   = {1'b0, surf_width_reg} + round_mask;
        tpr_full   = width_up >> tw_sh;
        col_full   = coord_x >> tw_sh;
        row_full   = coord_y >> th_sh;
    end

    logic                               err1_reg;
    logic [tsas_pkg::LOCAL_W-1:0]       local1_reg;
    logic [tsas_pkg::ROW_W-1:0]         col1_reg, row1_reg;
    logic [tsas_pkg::TPR_W-1:0]         tpr1_reg;

    always_ff @(posedge clk)
    begin
        if (ready1)
        begin
            err1_reg   <= err1_next;
            local1_reg <= local1_next;
            col1_reg   <= col_full[tsas_pkg::ROW_W-1:0];
            row1_reg   <= row_full[tsas_pkg::ROW_W-1:0];
            tpr1_reg   <= tpr_full[tsas_pkg::TPR_W-1:0];
        end
    end

    // stage 2: tile row times tiles per row
    logic                               err2_reg;
    logic [tsas_pkg::LOCAL_W-1:0]       local2_reg;
    logic [tsas_pkg::ROW_W-1:0]         col2_reg;
    logic [tsas_pkg::PROD_W-1:0]        prod2_reg;

    always_ff @(posedge clk)
    begin
        if (ready2)
        begin
            err2_reg   <= err1_reg;
            local2_reg <= local1_reg;
            col2_reg   <= col1_reg;
            prod2_reg  <= tsas_pkg::PROD_W'(row1_reg) * tsas_pkg::PROD_W'(tpr1_reg);
        end
    end

    // stage 3: tile index, full offset, overflow
    logic [tsas_pkg::IDX_W-1:0] tile_idx;
    logic [tsas_pkg::SUM_W-1:0] sum;
    logic                       err3_next;
    logic [tsas_pkg::OFFS_W-1:0] offs3_next;

    always_comb
    begin
        tile_idx  = tsas_pkg::IDX_W'(prod2_reg) + tsas_pkg::IDX_W'(col2_reg);
        sum       = tsas_pkg::SUM_W'({tile_idx, {tsas_pkg::TILE_LOG2{1'b0}}})
                  + tsas_pkg::SUM_W'(local2_reg);
        err3_next = err2_reg || (|sum[tsas_pkg::SUM_W-1:tsas_pkg::OFFS_W]);
        offs3_next = err3_next ? '0 : sum[tsas_pkg::OFFS_W-1:0];
    end

    logic                        err3_reg;
    logic [tsas_pkg::OFFS_W-1:0] offs3_reg;

    always_ff @(posedge clk)
    begin
        if (ready3)
        begin
            err3_reg  <= err3_next;
            offs3_reg <= offs3_next;
        end
    end

    assign out_valid   = v3_reg;
    assign byte_offset = offs3_reg;
    assign addr_error  = err3_reg;

    // checks
    `TSAS_ASSERT_NOW(a_err_zero, out_valid && addr_error, byte_offset == '0)
    `TSAS_ASSERT_NEXT(a_in_to_s1, in_valid && in_ready, v1_reg)
    `TSAS_ASSERT_NEXT(a_s1_hold, v1_reg && !ready2, v1_reg && $stable(tpr1_reg))
    `TSAS_ASSERT_NEXT(a_s2_to_out, v2_reg && ready3, out_valid)

endmodule
